>>> hdl/qlbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlbs_pkg
// Shared types and constants for the QSPI display beat serializer.
// ----------------------------------------------------------------------------
package qlbs_pkg;

   // operation codes on the request side
   typedef enum logic [2:0] {
      OP_WRITE_CMD   = 3'd0,
      OP_WRITE_PARAM = 3'd1,
      OP_READ_CMD    = 3'd2,
      OP_READ_BYTE   = 3'd3,
      OP_PIXEL_START = 3'd4,
      OP_PIXEL       = 3'd5
   } op_type;

   // configuration register indexes
   localparam logic [7:0] REG_WRITE_PREFIX  = 8'd0;
   localparam logic [7:0] REG_READ_PREFIX   = 8'd1;
   localparam logic [7:0] REG_QUAD_PREFIX   = 8'd2;
   localparam logic [7:0] REG_PIXEL_COMMAND = 8'd3;

   // configuration reset values
   localparam logic [7:0] WRITE_PREFIX_RESET  = 8'h02;
   localparam logic [7:0] READ_PREFIX_RESET   = 8'h03;
   localparam logic [7:0] QUAD_PREFIX_RESET   = 8'h12;
   localparam logic [7:0] PIXEL_COMMAND_RESET = 8'h2C;

   // beat counts per operation
   localparam logic [5:0] SINGLE_BYTE_BEATS  = 6'd8;
   localparam logic [5:0] SINGLE_FRAME_BEATS = 6'd32;
   localparam logic [2:0] QUAD_HEADER_BEATS  = 3'd6;
   localparam logic [2:0] QUAD_PIXEL_BEATS   = 3'd4;

   // depth of the work queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // one classified operation: single-line beats first, then quad beats,
   // then an optional closing beat
   typedef struct packed {
      logic [31:0] word;
      logic [5:0]  single_cnt;
      logic [2:0]  quad_cnt;
      logic        read;
      logic        close;
   } desc_type;

endpackage

>>> hdl/qlbs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlbs_front
// Accepts operations, holds the configuration registers and turns each
// operation into a beat descriptor for the work queue.
// ----------------------------------------------------------------------------
module qlbs_front import qlbs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_opcode,
   input  logic [7:0]  req_cmd_byte,
   input  logic [7:0]  req_data_byte,
   input  logic [15:0] req_pixel_value,
   input  logic        req_end_after,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_data,
   output logic        q_push,
   output desc_type    q_desc,
   input  logic        q_full
);

   logic     [7:0] write_prefix_ff, write_prefix_in;
   logic     [7:0] read_prefix_ff, read_prefix_in;
   logic     [7:0] quad_prefix_ff, quad_prefix_in;
   logic     [7:0] pixel_command_ff, pixel_command_in;
   logic           stage_valid_ff, stage_valid_in;
   desc_type       stage_desc_ff, stage_desc_in;
   desc_type       desc_new;
   logic           op_known;
   logic           stage_ready;

   // configuration register writes, reserved indexes dropped
   assign csr_ready = 1'b1;

   always_comb begin
      write_prefix_in  = write_prefix_ff;
      read_prefix_in   = read_prefix_ff;
      quad_prefix_in   = quad_prefix_ff;
      pixel_command_in = pixel_command_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_WRITE_PREFIX:  write_prefix_in  = csr_data;
            REG_READ_PREFIX:   read_prefix_in   = csr_data;
            REG_QUAD_PREFIX:   quad_prefix_in   = csr_data;
            REG_PIXEL_COMMAND: pixel_command_in = csr_data;
            default: ;
         endcase
      end
   end

   // classify the operation into a beat descriptor
   always_comb begin
      desc_new.word       = '0;
      desc_new.single_cnt = '0;
      desc_new.quad_cnt   = '0;
      desc_new.read       = 1'b0;
      desc_new.close      = req_end_after;
      op_known            = 1'b1;
      case (op_type'(req_opcode))
         OP_WRITE_CMD: begin
            desc_new.word       = {write_prefix_ff, 8'h00, req_cmd_byte, 8'h00};
            desc_new.single_cnt = SINGLE_FRAME_BEATS;
         end
         OP_READ_CMD: begin
            desc_new.word       = {read_prefix_ff, 8'h00, req_cmd_byte, 8'h00};
            desc_new.single_cnt = SINGLE_FRAME_BEATS;
         end
         OP_WRITE_PARAM: begin
            desc_new.word       = {req_data_byte, 24'h000000};
            desc_new.single_cnt = SINGLE_BYTE_BEATS;
         end
         OP_READ_BYTE: begin
            desc_new.single_cnt = SINGLE_BYTE_BEATS;
            desc_new.read       = 1'b1;
         end
         OP_PIXEL_START: begin
            desc_new.word       = {quad_prefix_ff, 8'h00, pixel_command_ff, 8'h00};
            desc_new.single_cnt = SINGLE_BYTE_BEATS;
            desc_new.quad_cnt   = QUAD_HEADER_BEATS;
         end
         OP_PIXEL: begin
            desc_new.word     = {req_pixel_value, 16'h0000};
            desc_new.quad_cnt = QUAD_PIXEL_BEATS;
         end
         default: op_known = 1'b0;
      endcase
   end

   // one-entry stage in front of the queue; unknown opcodes vanish here
   assign stage_ready = !stage_valid_ff || !q_full;
   assign req_full    = !stage_ready;
   assign q_push      = stage_valid_ff && !q_full;
   assign q_desc      = stage_desc_ff;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_desc_in  = stage_desc_ff;
      if (stage_ready) begin
         stage_valid_in = req_push && op_known;
         stage_desc_in  = desc_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_prefix_ff  <= WRITE_PREFIX_RESET;
         read_prefix_ff   <= READ_PREFIX_RESET;
         quad_prefix_ff   <= QUAD_PREFIX_RESET;
         pixel_command_ff <= PIXEL_COMMAND_RESET;
         stage_valid_ff   <= 1'b0;
      end else begin
         write_prefix_ff  <= write_prefix_in;
         read_prefix_ff   <= read_prefix_in;
         quad_prefix_ff   <= quad_prefix_in;
         pixel_command_ff <= pixel_command_in;
         stage_valid_ff   <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_desc_ff <= stage_desc_in;
   end

endmodule

>>> hdl/qlbs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlbs_queue
// Short descriptor queue that decouples the front from the beat generator.
// ----------------------------------------------------------------------------
module qlbs_queue import qlbs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   output logic     full,
   input  logic     pop,
   output desc_type head,
   output logic     empty
);

   desc_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]    count_ff, count_in;
   logic                 do_push, do_pop;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue fill count out of range");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("transfer pushed into full queue");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");

endmodule

>>> hdl/qlbs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlbs_back
// Beat generator: shifts each descriptor out as single-line, quad and
// closing beats into an output register.
// ----------------------------------------------------------------------------
module qlbs_back import qlbs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  desc_type   q_head,
   input  logic       q_empty,
   output logic       q_pop,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_cs_n,
   output logic       rsp_clock_pulse,
   output logic [3:0] rsp_d_lines,
   output logic       rsp_d0_input,
   output logic       rsp_last_beat
);

   logic [31:0] word_ff, word_in;
   logic [5:0]  single_cnt_ff, single_cnt_in;
   logic [2:0]  quad_cnt_ff, quad_cnt_in;
   logic        read_ff, read_in;
   logic        close_ff, close_in;
   logic        out_valid_ff, out_valid_in;
   logic        cs_n_ff, clk_ff, d0_in_ff, last_ff;
   logic [3:0]  d_ff;
   logic        active, advance, load;
   logic        beat_cs_n, beat_clk, beat_rd, beat_last;
   logic [3:0]  beat_d;

   assign active  = (single_cnt_ff != '0) || (quad_cnt_ff != '0) || close_ff;
   assign advance = active && (!out_valid_ff || rsp_pop);

   // current beat and the remaining work after it
   always_comb begin
      beat_cs_n     = 1'b0;
      beat_clk      = 1'b1;
      beat_d        = '0;
      beat_rd       = 1'b0;
      beat_last     = 1'b0;
      word_in       = word_ff;
      single_cnt_in = single_cnt_ff;
      quad_cnt_in   = quad_cnt_ff;
      read_in       = read_ff;
      close_in      = close_ff;
      if (single_cnt_ff != '0) begin
         beat_d        = read_ff ? 4'h0 : {3'b000, word_ff[31]};
         beat_rd       = read_ff;
         beat_last     = (single_cnt_ff == 6'd1) && (quad_cnt_ff == '0) && !close_ff;
         single_cnt_in = single_cnt_ff - 1'b1;
         word_in       = {word_ff[30:0], 1'b0};
      end else if (quad_cnt_ff != '0) begin
         beat_d      = word_ff[31:28];
         beat_last   = (quad_cnt_ff == 3'd1) && !close_ff;
         quad_cnt_in = quad_cnt_ff - 1'b1;
         word_in     = {word_ff[27:0], 4'h0};
      end else begin
         beat_cs_n = 1'b1;
         beat_clk  = 1'b0;
         beat_last = 1'b1;
         close_in  = 1'b0;
      end
      // next descriptor enters as the last beat of this one leaves
      if (load) begin
         word_in       = q_head.word;
         single_cnt_in = q_head.single_cnt;
         quad_cnt_in   = q_head.quad_cnt;
         read_in       = q_head.read;
         close_in      = q_head.close;
      end else if (!advance) begin
         word_in       = word_ff;
         single_cnt_in = single_cnt_ff;
         quad_cnt_in   = quad_cnt_ff;
         close_in      = close_ff;
      end
   end

   assign load  = !q_empty && (!active || (advance && beat_last));
   assign q_pop = load;

   // output register valid
   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         single_cnt_ff <= '0;
         quad_cnt_ff   <= '0;
         close_ff      <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         single_cnt_ff <= single_cnt_in;
         quad_cnt_ff   <= quad_cnt_in;
         close_ff      <= close_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // shift word and beat payload
   always_ff @(posedge clock) begin
      word_ff <= word_in;
      read_ff <= read_in;
      if (advance) begin
         cs_n_ff  <= beat_cs_n;
         clk_ff   <= beat_clk;
         d_ff     <= beat_d;
         d0_in_ff <= beat_rd;
         last_ff  <= beat_last;
      end
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_cs_n        = cs_n_ff;
   assign rsp_clock_pulse = clk_ff;
   assign rsp_d_lines     = d_ff;
   assign rsp_d0_input    = d0_in_ff;
   assign rsp_last_beat   = last_ff;

   // checks
   a_close_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && cs_n_ff) |-> (last_ff && !clk_ff && d_ff == 4'h0))
      else $error("closing beat malformed");

   a_read_released: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && d0_in_ff) |-> (d_ff == 4'h0 && !cs_n_ff))
      else $error("read beat drives data lines");

   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      load |=> active)
      else $error("descriptor loaded without work");

endmodule

>>> hdl/qspi_lcd_beat_serializer_top.sv
`timescale 1ns / 1ps
// Path: a push passes the front stage register, the work queue, the beat generator and the
//   output register. Beats: pixel 4, parameter or read byte 8, pixel start 14, commands 32,
//   plus a closing beat when req_end_after is set. Throughput: one beat per cycle while
//   rsp_pop drains the output register, with no gap between queued operations.
// Reset: synchronous, active high; config registers return to their defaults and all
//   queued work and pending beats are dropped.
// ----------------------------------------------------------------------------
// qspi_lcd_beat_serializer_top
// QSPI display beat serializer: front classifier, work queue, beat generator.
// ----------------------------------------------------------------------------
module qspi_lcd_beat_serializer_top import qlbs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_opcode,
   input  logic [7:0]  req_cmd_byte,
   input  logic [7:0]  req_data_byte,
   input  logic [15:0] req_pixel_value,
   input  logic        req_end_after,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_cs_n,
   output logic        rsp_clock_pulse,
   output logic [3:0]  rsp_d_lines,
   output logic        rsp_d0_input,
   output logic        rsp_last_beat,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_data
);

   logic     q_push, q_full, q_pop, q_empty;
   desc_type q_desc, q_head;

   // accept and classify
   qlbs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_opcode      (req_opcode),
      .req_cmd_byte    (req_cmd_byte),
      .req_data_byte   (req_data_byte),
      .req_pixel_value (req_pixel_value),
      .req_end_after   (req_end_after),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .q_push          (q_push),
      .q_desc          (q_desc),
      .q_full          (q_full)
   );

   // decoupling queue
   qlbs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (q_desc),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   // beat generation
   qlbs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_head          (q_head),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_cs_n        (rsp_cs_n),
      .rsp_clock_pulse (rsp_clock_pulse),
      .rsp_d_lines     (rsp_d_lines),
      .rsp_d0_input    (rsp_d0_input),
      .rsp_last_beat   (rsp_last_beat)
   );

endmodule

>>> tb/tb_qspi_lcd_beat_serializer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_qspi_lcd_beat_serializer_top
// Self-checking bench for the QSPI display beat serializer. Display bus
// operations are pushed in random bursts and every beat is popped under a
// changing stall pattern. Each popped beat is checked field by field against
// beats built by an in-bench serializer. The register settings change between
// phases: defaults, all zeros, all ones and random values.
// ----------------------------------------------------------------------------
module tb_qspi_lcd_beat_serializer_top;
   import qlbs_pkg::*;

   // opcodes that the block ignores
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 12;
   localparam int LONG_HOLD    = 500;
   localparam int SEGMENT_OPS  = 32;

   typedef struct {
      logic [2:0]  opcode;
      logic [7:0]  cmd_byte;
      logic [7:0]  data_byte;
      logic [15:0] pixel_value;
      logic        end_after;
   } bus_op_type;

   typedef struct {
      logic       cs_n;
      logic       clock_pulse;
      logic [3:0] d_lines;
      logic       d0_input;
      logic       last_beat;
   } beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [2:0]  req_opcode = '0;
   logic [7:0]  req_cmd_byte = '0;
   logic [7:0]  req_data_byte = '0;
   logic [15:0] req_pixel_value = '0;
   logic        req_end_after = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic        rsp_cs_n;
   logic        rsp_clock_pulse;
   logic [3:0]  rsp_d_lines;
   logic        rsp_d0_input;
   logic        rsp_last_beat;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   qspi_lcd_beat_serializer_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_opcode      (req_opcode),
      .req_cmd_byte    (req_cmd_byte),
      .req_data_byte   (req_data_byte),
      .req_pixel_value (req_pixel_value),
      .req_end_after   (req_end_after),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_cs_n        (rsp_cs_n),
      .rsp_clock_pulse (rsp_clock_pulse),
      .rsp_d_lines     (rsp_d_lines),
      .rsp_d0_input    (rsp_d0_input),
      .rsp_last_beat   (rsp_last_beat),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // clock: 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // serializer state and register copies
   logic [7:0] cfg_write_prefix  = WRITE_PREFIX_RESET;
   logic [7:0] cfg_read_prefix   = READ_PREFIX_RESET;
   logic [7:0] cfg_quad_prefix   = QUAD_PREFIX_RESET;
   logic [7:0] cfg_pixel_command = PIXEL_COMMAND_RESET;
   bit         select_active = 1'b0;

   bus_op_type pending_ops[$];
   beat_type   expected_beats[$];
   beat_type   staged_beat;
   bit         beat_staged = 1'b0;
   int         queued_cnt = 0;
   int         accepted_cnt = 0;
   int         long_hold_at = 32'h7fff_ffff;
   int         err_cnt = 0;
   int         cycle_cnt = 0;

   // beats are staged one behind so the final one of an operation can be marked
   function automatic void stage_beat(logic cs, logic clk, logic [3:0] d, logic rd);
      if (beat_staged) expected_beats.push_back(staged_beat);
      staged_beat.cs_n        = cs;
      staged_beat.clock_pulse = clk;
      staged_beat.d_lines     = d;
      staged_beat.d0_input    = rd;
      staged_beat.last_beat   = 1'b0;
      beat_staged             = 1'b1;
   endfunction

   // single-line byte, MSB first on D0
   function automatic void stage_serial_byte(logic [7:0] b);
      for (int i = 7; i >= 0; i--) stage_beat(1'b0, 1'b1, {3'b000, b[i]}, 1'b0);
   endfunction

   // quad byte, high nibble first
   function automatic void stage_quad_byte(logic [7:0] b);
      stage_beat(1'b0, 1'b1, b[7:4], 1'b0);
      stage_beat(1'b0, 1'b1, b[3:0], 1'b0);
   endfunction

   // expected beats of one accepted operation
   function automatic void serialize_op(bus_op_type op);
      case (op.opcode)
         OP_WRITE_CMD, OP_READ_CMD: begin
            stage_serial_byte(op.opcode == OP_WRITE_CMD ? cfg_write_prefix : cfg_read_prefix);
            stage_serial_byte(8'h00);
            stage_serial_byte(op.cmd_byte);
            stage_serial_byte(8'h00);
         end
         OP_WRITE_PARAM: begin
            stage_serial_byte(op.data_byte);
         end
         OP_READ_BYTE: begin
            for (int i = 0; i < 8; i++) stage_beat(1'b0, 1'b1, 4'h0, 1'b1);
         end
         OP_PIXEL_START: begin
            stage_serial_byte(cfg_quad_prefix);
            stage_quad_byte(8'h00);
            stage_quad_byte(cfg_pixel_command);
            stage_quad_byte(8'h00);
         end
         OP_PIXEL: begin
            for (int i = 3; i >= 0; i--) stage_beat(1'b0, 1'b1, op.pixel_value[4*i +: 4], 1'b0);
         end
         default: begin
            return;
         end
      endcase
      select_active = 1'b1;
      // closing beat raises chip select, even when already inactive
      if (op.end_after) begin
         stage_beat(1'b1, 1'b0, 4'h0, 1'b0);
         select_active = 1'b0;
      end
      staged_beat.last_beat = 1'b1;
      expected_beats.push_back(staged_beat);
      beat_staged = 1'b0;
   endfunction

   // request driver: bursts of pushes with random gaps
   bus_op_type cur_op;
   bit         offering = 1'b0;
   int         burst_left = 0;
   int         gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (offering && req_push && !req_full) begin
            serialize_op(cur_op);
            accepted_cnt++;
            offering = 1'b0;
         end
         if (!offering) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_ops.size() > 0) begin
               cur_op = pending_ops.pop_front();
               req_opcode      <= cur_op.opcode;
               req_cmd_byte    <= cur_op.cmd_byte;
               req_data_byte   <= cur_op.data_byte;
               req_pixel_value <= cur_op.pixel_value;
               req_end_after   <= cur_op.end_after;
               offering = 1'b1;
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 16);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
         req_push <= offering;
      end
   end

   // response side: a stall mode drawn at random and redrawn while running, plus one long hold-off
   int         hold_left = 0;
   bit         long_hold_done = 1'b0;
   int         mode_left = 0;
   int         stall_mode = 0;
   logic [7:0] stall_pattern = 8'hff;
   int         pat_pos = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            mode_left     = 64;
            stall_mode    = $urandom_range(0, 3);
            stall_pattern = 8'($urandom);
         end
         mode_left--;
         pat_pos = (pat_pos + 1) % 8;
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (!long_hold_done && accepted_cnt >= long_hold_at) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD;
            rsp_pop <= 1'b0;
         end else begin
            case (stall_mode)
               0: rsp_pop <= 1'b1;
               1: rsp_pop <= 1'($urandom_range(0, 1));
               2: rsp_pop <= stall_pattern[pat_pos];
               default: rsp_pop <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // beat checker
   beat_type exp_beat;

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_beats.size() == 0) begin
            $error("unexpected beat: cs_n %0d d_lines %h", rsp_cs_n, rsp_d_lines);
            err_cnt++;
         end else begin
            exp_beat = expected_beats.pop_front();
            if (rsp_cs_n !== exp_beat.cs_n) begin
               $error("cs_n: expected %0d, got %0d", exp_beat.cs_n, rsp_cs_n);
               err_cnt++;
            end
            if (rsp_clock_pulse !== exp_beat.clock_pulse) begin
               $error("clock_pulse: expected %0d, got %0d", exp_beat.clock_pulse,
                      rsp_clock_pulse);
               err_cnt++;
            end
            if (rsp_d_lines !== exp_beat.d_lines) begin
               $error("d_lines: expected %h, got %h", exp_beat.d_lines, rsp_d_lines);
               err_cnt++;
            end
            if (rsp_d0_input !== exp_beat.d0_input) begin
               $error("d0_input: expected %0d, got %0d", exp_beat.d0_input, rsp_d0_input);
               err_cnt++;
            end
            if (rsp_last_beat !== exp_beat.last_beat) begin
               $error("last_beat: expected %0d, got %0d", exp_beat.last_beat, rsp_last_beat);
               err_cnt++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("tb_qspi_lcd_beat_serializer_top NOT OK");
         $finish;
      end
   end

   function automatic void queue_op(logic [2:0] opc, logic [7:0] cmd, logic [7:0] dat,
                                    logic [15:0] px, logic endf);
      bus_op_type op;
      op.opcode      = opc;
      op.cmd_byte    = cmd;
      op.data_byte   = dat;
      op.pixel_value = px;
      op.end_after   = endf;
      pending_ops.push_back(op);
      queued_cnt++;
   endfunction

   // random operation with random payload
   function automatic void queue_rand(logic [2:0] opc, logic endf);
      queue_op(opc, 8'($urandom), 8'($urandom), 16'($urandom), endf);
   endfunction

   // mostly well-formed transactions, the rest noise
   function automatic void queue_random_segment(int count);
      int valid_ops;
      int kind;
      int n;
      valid_ops = 0;
      while (valid_ops < count) begin
         kind = $urandom_range(0, 9);
         if (kind <= 3) begin
            // pixel stream, usually closed at the end
            n = $urandom_range(1, 8);
            queue_rand(OP_PIXEL_START, 1'b0);
            for (int i = 0; i < n; i++)
               queue_rand(OP_PIXEL, (i == n - 1) && ($urandom_range(0, 3) != 0));
            valid_ops += n + 1;
         end else if (kind <= 5) begin
            // command write with parameters
            n = $urandom_range(0, 3);
            queue_rand(OP_WRITE_CMD, n == 0);
            for (int i = 0; i < n; i++) queue_rand(OP_WRITE_PARAM, i == n - 1);
            valid_ops += n + 1;
         end else if (kind == 6) begin
            // command read with read bytes
            n = $urandom_range(1, 2);
            queue_rand(OP_READ_CMD, 1'b0);
            for (int i = 0; i < n; i++) queue_rand(OP_READ_BYTE, i == n - 1);
            valid_ops += n + 1;
         end else begin
            n = $urandom_range(0, 7);
            queue_rand(n[2:0], 1'($urandom_range(0, 1)));
            if (n < 6) valid_ops++;
         end
      end
   endfunction

   // register write; the copy follows at the transfer
   task automatic write_reg(logic [7:0] idx, logic [7:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_WRITE_PREFIX:  cfg_write_prefix  = val;
         REG_READ_PREFIX:   cfg_read_prefix   = val;
         REG_QUAD_PREFIX:   cfg_quad_prefix   = val;
         REG_PIXEL_COMMAND: cfg_pixel_command = val;
         default: ;
      endcase
   endtask

   task automatic write_all_regs(logic [7:0] wp, logic [7:0] rp, logic [7:0] qp,
                                 logic [7:0] pc);
      write_reg(REG_WRITE_PREFIX, wp);
      write_reg(REG_READ_PREFIX, rp);
      write_reg(REG_QUAD_PREFIX, qp);
      write_reg(REG_PIXEL_COMMAND, pc);
   endtask

   // sender waits here until every beat is back and the block is idle
   task automatic wait_drained();
      do @(posedge clock); while (accepted_cnt != queued_cnt || expected_beats.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed operations under reset register values
      queue_op(OP_WRITE_CMD,   8'h00, 8'h00, 16'h0000, 1'b0);
      queue_op(OP_WRITE_PARAM, 8'h00, 8'hff, 16'h0000, 1'b0);
      queue_op(OP_WRITE_PARAM, 8'hff, 8'h00, 16'hffff, 1'b1);
      // closing again right after a close
      queue_op(OP_WRITE_PARAM, 8'h00, 8'h81, 16'h0000, 1'b1);
      queue_op(OP_READ_CMD,    8'hff, 8'h00, 16'h0000, 1'b0);
      queue_op(OP_READ_BYTE,   8'h00, 8'hff, 16'hffff, 1'b0);
      queue_op(OP_READ_BYTE,   8'h00, 8'h00, 16'h0000, 1'b1);
      queue_op(OP_PIXEL_START, 8'h00, 8'h00, 16'h0000, 1'b0);
      queue_op(OP_PIXEL,       8'h00, 8'h00, 16'h0000, 1'b0);
      queue_op(OP_PIXEL,       8'hff, 8'hff, 16'hffff, 1'b0);
      queue_op(OP_PIXEL,       8'h00, 8'h00, 16'h1234, 1'b1);
      // spare opcodes produce nothing, close flag included
      queue_op(OP_SPARE_LO,    8'h5a, 8'ha5, 16'h8001, 1'b1);
      queue_op(OP_SPARE_HI,    8'hff, 8'hff, 16'hffff, 1'b0);
      queue_op(OP_PIXEL_START, 8'hff, 8'hff, 16'hffff, 1'b1);
      queue_op(OP_PIXEL,       8'h00, 8'h00, 16'ha5c3, 1'b1);
      queue_op(OP_WRITE_CMD,   8'hff, 8'h00, 16'h0000, 1'b1);
      queue_op(OP_READ_CMD,    8'h00, 8'h00, 16'h0000, 1'b1);
      queue_op(OP_SPARE_HI,    8'h00, 8'h00, 16'h0000, 1'b1);
      wait_drained();

      // all registers at zero; writes beyond the last index are dropped
      write_all_regs(8'h00, 8'h00, 8'h00, 8'h00);
      write_reg(8'd4, 8'hff);
      write_reg(8'hff, 8'hff);
      queue_random_segment(SEGMENT_OPS);
      wait_drained();

      // all registers at ones, long response hold-off during this phase
      write_all_regs(8'hff, 8'hff, 8'hff, 8'hff);
      long_hold_at = queued_cnt + 10;
      queue_random_segment(SEGMENT_OPS);
      wait_drained();

      // random register values
      write_all_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      write_reg(8'($urandom_range(4, 255)), 8'($urandom));
      queue_random_segment(SEGMENT_OPS);
      wait_drained();

      write_all_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      queue_random_segment(SEGMENT_OPS);
      wait_drained();

      if (err_cnt == 0) begin
         $display("tb_qspi_lcd_beat_serializer_top OK");
      end else begin
         $display("tb_qspi_lcd_beat_serializer_top NOT OK");
      end
      $finish;
   end

endmodule
